### design/quote_order_state_table_unit_defines.svh
// assertion macros used by the checker file of the quote order state table
// no dependencies; the including file provides clk_i and rst_ni for QOST_ASSERT
`ifndef QUOTE_ORDER_STATE_TABLE_UNIT_DEFINES_SVH
`define QUOTE_ORDER_STATE_TABLE_UNIT_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define QOST_ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define QOST_ASSERT(label, prop, msg) \
  `QOST_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### design/qost_pkg.sv
// shared types, widths and codes of the quote order state table
// no dependencies
package qost_pkg;

  // table geometry
  localparam int unsigned TICKER_COUNT = 8;
  localparam int unsigned SIDE_COUNT   = 2;
  localparam int unsigned TICK_AW      = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1;

  // field widths
  localparam int unsigned TICKER_W = 3;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned CLIENT_W = 16;
  localparam int unsigned RTYPE_W  = 3;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // single-bit codes
  localparam logic OP_MOVE    = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;
  localparam logic REQ_NEW    = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  typedef logic [TICK_AW-1:0] tick_t;

  typedef enum logic [2:0] {
    ENT_INVALID     = 3'd0,
    ENT_PEND_NEW    = 3'd1,
    ENT_LIVE        = 3'd2,
    ENT_PEND_CANCEL = 3'd3,
    ENT_DEAD        = 3'd4
  } entry_status_e;

  typedef enum logic [RTYPE_W-1:0] {
    RESP_ACCEPTED   = 3'd0,
    RESP_CANCELED   = 3'd1,
    RESP_FILLED     = 3'd2,
    RESP_CXL_REJECT = 3'd3,
    RESP_INVALID    = 3'd4
  } resp_type_e;

  // what an exchange update does to its entry
  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_LIVE = 2'd1,
    UPD_DEAD = 2'd2,
    UPD_FILL = 2'd3
  } upd_action_e;

  // classified word held in the queue
  typedef struct packed {
    logic                                is_update;
    tick_t                               ticker;
    logic [SIDE_COUNT-1:0][PRICE_W-1:0]  price;
    logic [SIDE_COUNT-1:0]               px_valid;
    logic [SIDE_COUNT-1:0]               risk_ok;
    logic [QTY_W-1:0]                    clip;
    upd_action_e                         action;
    logic                                side;
    logic [QTY_W-1:0]                    leaves;
  } qost_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

  // per-side decision of a move
  typedef struct packed {
    logic emit;
    logic cancel;
  } side_dec_t;

endpackage

### design/qost_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module qost_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/qost_queue.sv
// short fifo of classified words between front and back
// depends on qost_pkg
module qost_queue import qost_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qost_item_t push_item_i,
  input  logic       pop_i,
  output q_stat_t    stat_o,
  output qost_item_t head_o
);

  qost_item_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign stat_o.full       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.head_valid = (count_q != '0);
  assign head_o            = slot_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/qost_front.sv
// front end: accepts input words, drops out-of-range tickers, decodes updates
// depends on qost_pkg
module qost_front import qost_pkg::*; (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [TICKER_W-1:0] ticker_i,
  input  logic [PRICE_W-1:0]  bid_price_i,
  input  logic                bid_valid_i,
  input  logic [PRICE_W-1:0]  ask_price_i,
  input  logic                ask_valid_i,
  input  logic [QTY_W-1:0]    clip_i,
  input  logic                bid_risk_ok_i,
  input  logic                ask_risk_ok_i,
  input  logic [RTYPE_W-1:0]  response_type_i,
  input  logic                response_side_i,
  input  logic [QTY_W-1:0]    leaves_qty_i,
  input  q_stat_t             q_stat_i,
  output logic                push_o,
  output qost_item_t          item_o
);

  logic in_range;

  // stall only on a full queue
  assign in_stall_o = q_stat_i.full;

  // an out-of-range ticker is taken and dropped
  assign in_range = (32'(ticker_i) < TICKER_COUNT);
  assign push_o   = in_valid_i && !q_stat_i.full && in_range;

  // build the queue word, sides gathered into lanes
  always_comb begin
    item_o.is_update  = (operation_i == OP_UPDATE);
    item_o.ticker     = TICK_AW'(ticker_i);
    item_o.price[0]   = bid_price_i;
    item_o.price[1]   = ask_price_i;
    item_o.px_valid   = {ask_valid_i, bid_valid_i};
    item_o.risk_ok    = {ask_risk_ok_i, bid_risk_ok_i};
    item_o.clip       = clip_i;
    item_o.side       = response_side_i;
    item_o.leaves     = leaves_qty_i;
    case (resp_type_e'(response_type_i))
      RESP_ACCEPTED: item_o.action = UPD_LIVE;
      RESP_CANCELED: item_o.action = UPD_DEAD;
      RESP_FILLED:   item_o.action = UPD_FILL;
      default:       item_o.action = UPD_NONE;
    endcase
  end

endmodule

### design/qost_back.sv
// back end: entry table, order-id counter, request sequencing and result register
// depends on qost_pkg and qost_ram
module qost_back import qost_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CLIENT_W-1:0] cfg_wdata_i,
  input  q_stat_t             q_stat_i,
  input  qost_item_t          head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                request_kind_o,
  output logic [CLIENT_W-1:0] request_client_o,
  output logic [TICKER_W-1:0] request_ticker_o,
  output logic [ID_W-1:0]     request_order_id_o,
  output logic                request_side_o,
  output logic [PRICE_W-1:0]  request_price_o,
  output logic [QTY_W-1:0]    request_qty_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUY  = 3'b010,
    S_SELL = 3'b100
  } back_state_e;

  back_state_e         state_q, state_d;
  qost_item_t          item_q, item_d;
  logic [ID_W-1:0]     next_id_q, next_id_d;
  logic [CLIENT_W-1:0] client_q;
  entry_status_e       status_q [TICKER_COUNT][SIDE_COUNT];

  // entry store ports
  tick_t                    rd_addr, wr_addr;
  logic [SIDE_COUNT-1:0]    idp_we, qty_we;
  logic [ID_W+PRICE_W-1:0]  idp_wdata;
  logic [QTY_W-1:0]         qty_wdata;
  logic [ID_W+PRICE_W-1:0]  idp_rdata [SIDE_COUNT];
  logic [QTY_W-1:0]         qty_rdata [SIDE_COUNT];
  logic [ID_W-1:0]          st_id [SIDE_COUNT];
  logic [PRICE_W-1:0]       st_px [SIDE_COUNT];

  // status write port
  logic          st_we, st_ws;
  entry_status_e st_wv;

  side_dec_t dec [SIDE_COUNT];
  side_dec_t cur_dec;
  logic      cur, out_free, fire, advance, chain;

  // one id/price ram and one quantity ram per side, addressed by ticker
  for (genvar s = 0; s < SIDE_COUNT; s++) begin : g_side
    qost_ram #(
      .WIDTH(ID_W + PRICE_W),
      .DEPTH(TICKER_COUNT)
    ) u_idp_ram (
      .clk_i  (clk_i),
      .we_i   (idp_we[s]),
      .waddr_i(wr_addr),
      .wdata_i(idp_wdata),
      .raddr_i(rd_addr),
      .rdata_o(idp_rdata[s])
    );

    qost_ram #(
      .WIDTH(QTY_W),
      .DEPTH(TICKER_COUNT)
    ) u_qty_ram (
      .clk_i  (clk_i),
      .we_i   (qty_we[s]),
      .waddr_i(wr_addr),
      .wdata_i(qty_wdata),
      .raddr_i(rd_addr),
      .rdata_o(qty_rdata[s])
    );
  end

  // both sides decided from the same read, so the buy request knows if it is last
  always_comb begin
    for (int s = 0; s < SIDE_COUNT; s++) begin
      st_px[s] = idp_rdata[s][PRICE_W-1:0];
      st_id[s] = idp_rdata[s][ID_W+PRICE_W-1:PRICE_W];
      dec[s].cancel = (status_q[item_q.ticker][s] == ENT_LIVE) &&
                      (!item_q.px_valid[s] || (st_px[s] != item_q.price[s]) ||
                       (qty_rdata[s] != item_q.clip));
      dec[s].emit = dec[s].cancel ||
                    ((status_q[item_q.ticker][s] inside {ENT_INVALID, ENT_DEAD}) &&
                     item_q.px_valid[s] && item_q.risk_ok[s]);
    end
  end

  assign cur      = (state_q == S_SELL);
  assign cur_dec  = dec[cur];
  assign out_free = !out_valid_o || !out_stall_i;
  assign chain    = q_stat_i.head_valid && !head_i.is_update &&
                    (head_i.ticker != item_q.ticker);

  // sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    next_id_d = next_id_q;
    pop_o     = 1'b0;
    rd_addr   = item_q.ticker;
    wr_addr   = item_q.ticker;
    idp_we    = '0;
    qty_we    = '0;
    idp_wdata = {next_id_q, item_q.price[cur]};
    qty_wdata = item_q.clip;
    st_we     = 1'b0;
    st_ws     = cur;
    st_wv     = ENT_PEND_NEW;
    fire      = 1'b0;
    advance   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_stat_i.head_valid) begin
          pop_o = 1'b1;
          if (head_i.is_update) begin
            // exchange update, done in place
            wr_addr   = head_i.ticker;
            st_ws     = head_i.side;
            qty_wdata = head_i.leaves;
            case (head_i.action)
              UPD_LIVE: begin
                st_we = 1'b1;
                st_wv = ENT_LIVE;
              end
              UPD_DEAD: begin
                st_we = 1'b1;
                st_wv = ENT_DEAD;
              end
              UPD_FILL: begin
                qty_we[head_i.side] = 1'b1;
                if (head_i.leaves == '0) begin
                  st_we = 1'b1;
                  st_wv = ENT_DEAD;
                end
              end
              default: ;
            endcase
          end else begin
            // move: read both sides of the ticker
            rd_addr = head_i.ticker;
            item_d  = head_i;
            state_d = S_BUY;
          end
        end
      end
      S_BUY, S_SELL: begin
        if (cur_dec.emit && out_free) begin
          fire  = 1'b1;
          st_we = 1'b1;
          if (cur_dec.cancel) begin
            st_wv = ENT_PEND_CANCEL;
          end else begin
            st_wv       = ENT_PEND_NEW;
            idp_we[cur] = 1'b1;
            qty_we[cur] = 1'b1;
            next_id_d   = next_id_q + ID_W'(1);
          end
        end
        advance = !cur_dec.emit || out_free;
        if (advance) begin
          if ((state_q == S_BUY) && dec[1].emit) begin
            state_d = S_SELL;
          end else if (chain) begin
            // next move on another ticker starts without an idle read cycle
            pop_o   = 1'b1;
            rd_addr = head_i.ticker;
            item_d  = head_i;
            state_d = S_BUY;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_id_q <= ID_W'(1);
      client_q  <= '0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      if (cfg_we_i) begin
        client_q <= cfg_wdata_i;
      end
    end
  end

  // entry status, cleared to invalid at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TICKER_COUNT; t++) begin
        for (int s = 0; s < SIDE_COUNT; s++) begin
          status_q[t][s] <= ENT_INVALID;
        end
      end
    end else if (st_we) begin
      status_q[wr_addr][st_ws] <= st_wv;
    end
  end

  // current move word
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      request_kind_o     <= cur_dec.cancel ? REQ_CANCEL : REQ_NEW;
      request_client_o   <= client_q;
      request_ticker_o   <= TICKER_W'(item_q.ticker);
      request_order_id_o <= cur_dec.cancel ? st_id[cur] : next_id_q;
      request_side_o     <= cur;
      request_price_o    <= cur_dec.cancel ? st_px[cur] : item_q.price[cur];
      request_qty_o      <= cur_dec.cancel ? qty_rdata[cur] : item_q.clip;
      last_o             <= cur || !dec[1].emit;
    end
  end

endmodule

### design/quote_order_state_table_unit.sv
// Path: with the back end idle, a move is read from the queue in the idle state and its buy
// request is registered from the buy state, a sell-only request from the sell state; output
// stalls delay both. Sequencing: an update is done in the idle state as it is popped; a move
// takes a read in the idle state, the buy state, and the sell state only when the sell side
// issues a request. Back-to-back moves on different tickers skip the idle read state.
// Reset: async active low; all entries invalid, next order id one, client id zero.
module quote_order_state_table_unit import qost_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CLIENT_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [TICKER_W-1:0] ticker_i,
  input  logic [PRICE_W-1:0]  bid_price_i,
  input  logic                bid_valid_i,
  input  logic [PRICE_W-1:0]  ask_price_i,
  input  logic                ask_valid_i,
  input  logic [QTY_W-1:0]    clip_i,
  input  logic                bid_risk_ok_i,
  input  logic                ask_risk_ok_i,
  input  logic [RTYPE_W-1:0]  response_type_i,
  input  logic                response_side_i,
  input  logic [QTY_W-1:0]    leaves_qty_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                request_kind_o,
  output logic [CLIENT_W-1:0] request_client_o,
  output logic [TICKER_W-1:0] request_ticker_o,
  output logic [ID_W-1:0]     request_order_id_o,
  output logic                request_side_o,
  output logic [PRICE_W-1:0]  request_price_o,
  output logic [QTY_W-1:0]    request_qty_o,
  output logic                last_o
);

  q_stat_t    q_stat;
  qost_item_t push_item, head_item;
  logic       push, pop;

  // front: accept and classify
  qost_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .ticker_i       (ticker_i),
    .bid_price_i    (bid_price_i),
    .bid_valid_i    (bid_valid_i),
    .ask_price_i    (ask_price_i),
    .ask_valid_i    (ask_valid_i),
    .clip_i         (clip_i),
    .bid_risk_ok_i  (bid_risk_ok_i),
    .ask_risk_ok_i  (ask_risk_ok_i),
    .response_type_i(response_type_i),
    .response_side_i(response_side_i),
    .leaves_qty_i   (leaves_qty_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .item_o         (push_item)
  );

  // decoupling queue
  qost_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .stat_o     (q_stat),
    .head_o     (head_item)
  );

  // back: table and requests
  qost_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .q_stat_i          (q_stat),
    .head_i            (head_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_kind_o    (request_kind_o),
    .request_client_o  (request_client_o),
    .request_ticker_o  (request_ticker_o),
    .request_order_id_o(request_order_id_o),
    .request_side_o    (request_side_o),
    .request_price_o   (request_price_o),
    .request_qty_o     (request_qty_o),
    .last_o            (last_o)
  );

endmodule

### design/qost_checker.sv
// port-level checker for the quote order state table, bound to the top level
// depends on qost_pkg and quote_order_state_table_unit_defines.svh
`include "quote_order_state_table_unit_defines.svh"

module qost_checker import qost_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input logic                kind_i,
  input logic [TICKER_W-1:0] ticker_i,
  input logic [ID_W-1:0]     order_id_i,
  input logic                side_i,
  input logic [PRICE_W-1:0]  price_i,
  input logic                last_i
);

  logic                out_fire;
  logic                pair_open_q;
  logic [TICKER_W-1:0] pair_ticker_q;
  logic                seen_new_q;
  logic [ID_W-1:0]     last_new_id_q;

  assign out_fire = out_valid_i && !out_stall_i;

  // track an open request pair and the last new-order id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_open_q   <= 1'b0;
      pair_ticker_q <= '0;
      seen_new_q    <= 1'b0;
      last_new_id_q <= '0;
    end else if (out_fire) begin
      pair_open_q   <= !last_i;
      pair_ticker_q <= ticker_i;
      if (kind_i == REQ_NEW) begin
        seen_new_q    <= 1'b1;
        last_new_id_q <= order_id_i;
      end
    end
  end

  // a stalled word holds
  `QOST_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(order_id_i) && $stable(price_i), "stalled request changed")

  // a request that is not last is always the buy side
  `QOST_ASSERT(a_first_is_buy, out_valid_i && !last_i |-> side_i == SIDE_BUY, "non-last request not on buy side")

  // the second request of a pair is the sell side of the same ticker and closes it
  `QOST_ASSERT(a_pair_close, out_fire && pair_open_q |-> side_i == SIDE_SELL && last_i && ticker_i == pair_ticker_q, "request pair broken")

  // new-order ids advance by one
  `QOST_ASSERT(a_id_step, out_fire && kind_i == REQ_NEW && seen_new_q |-> order_id_i == last_new_id_q + ID_W'(1), "order id did not advance by one")

endmodule

bind quote_order_state_table_unit qost_checker u_qost_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .kind_i     (request_kind_o),
  .ticker_i   (request_ticker_o),
  .order_id_i (request_order_id_o),
  .side_i     (request_side_o),
  .price_i    (request_price_o),
  .last_i     (last_o)
);
